/* rtl/rcn_pkg.sv */
// ----------------------------------------------------------------------------
// Rectangle candidate nesting: shared package
// Types, register indexes and constants used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package rcn_pkg;

   localparam int unsigned COORD_W  = 16;
   localparam int unsigned AREA_W   = 32;
   localparam int unsigned PARENT_W = 7;

   // Smallest side that a clipped box may have.
   localparam logic signed [COORD_W:0] MIN_SIDE = 17'sd8;
   // Parent code for a box with no enclosing box.
   localparam logic [PARENT_W-1:0] PARENT_NONE = 7'h7F;

   typedef enum logic [2:0] {
      CSR_VIEW_LEFT   = 3'd0,
      CSR_VIEW_TOP    = 3'd1,
      CSR_VIEW_RIGHT  = 3'd2,
      CSR_VIEW_BOTTOM = 3'd3,
      CSR_POINT_X     = 3'd4,
      CSR_POINT_Y     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
   } box_type;

   // One classified request as it travels through the queue.
   typedef struct packed {
      box_type box;
      logic    keep;
      logic    last;
   } entry_type;

   // Queue handshake between the front and back parts.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      box_type             box;
      logic [PARENT_W-1:0] parent_index;
      logic                none_found;
      logic                dropped_some;
      logic                final_item;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DUP,
      ST_AREA,
      ST_APPEND,
      ST_END,
      ST_EMPTY,
      ST_SEL,
      ST_PAR,
      ST_RANK,
      ST_EMIT
   } back_state_type;

   // True when outer holds inner; edges may touch.
   function automatic logic encloses(input box_type outer, input box_type inner);
      encloses = (inner.left >= outer.left) && (inner.top >= outer.top) &&
                 (inner.right <= outer.right) && (inner.bottom <= outer.bottom);
   endfunction

endpackage

`default_nettype wire

/* rtl/rcn_if.sv */
// ----------------------------------------------------------------------------
// Rectangle candidate nesting: channel interfaces
// Request, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcn_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] box_left;
   logic [15:0] box_top;
   logic [15:0] box_right;
   logic [15:0] box_bottom;
   logic        last_box;

   modport source (output valid, box_left, box_top, box_right, box_bottom, last_box,
                   input ready);
   modport sink   (input valid, box_left, box_top, box_right, box_bottom, last_box,
                   output ready);
endinterface

interface rcn_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_left;
   logic [15:0] out_top;
   logic [15:0] out_right;
   logic [15:0] out_bottom;
   logic [6:0]  parent_index;
   logic        none_found;
   logic        dropped_some;
   logic        final_item;

   modport source (output valid, out_left, out_top, out_right, out_bottom, parent_index,
                   none_found, dropped_some, final_item, input ready);
   modport sink   (input valid, out_left, out_top, out_right, out_bottom, parent_index,
                   none_found, dropped_some, final_item, output ready);
endinterface

interface rcn_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/rcn_front.sv */
// ----------------------------------------------------------------------------
// Rectangle candidate nesting: front part
// Holds the registers, tests each request against the point and clips it.
// ----------------------------------------------------------------------------
`default_nettype none

module rcn_front (
   input  wire                        clock,
   input  wire                        reset,
   rcn_req_if.sink                    req_chan,
   rcn_csr_if.sink                    csr_chan,
   input  rcn_pkg::queue_status_type  q_status,
   output logic                       q_push,
   output rcn_pkg::entry_type         q_entry
);

   logic signed [15:0] view_left_ff, view_top_ff, view_right_ff, view_bottom_ff;
   logic signed [15:0] point_x_ff, point_y_ff;

   logic signed [16:0] bl, bt, br, bb, cl, ct, cr, cb;
   logic signed [16:0] vl, vt, vr, vb, px, py;
   logic               hits_point, big_enough;
   logic signed [16:0] rel_l, rel_t, rel_r, rel_b;

   // Register writes are always taken.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_left_ff   <= '0;
         view_top_ff    <= '0;
         view_right_ff  <= '0;
         view_bottom_ff <= '0;
         point_x_ff     <= '0;
         point_y_ff     <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            rcn_pkg::CSR_VIEW_LEFT:   view_left_ff   <= csr_chan.data;
            rcn_pkg::CSR_VIEW_TOP:    view_top_ff    <= csr_chan.data;
            rcn_pkg::CSR_VIEW_RIGHT:  view_right_ff  <= csr_chan.data;
            rcn_pkg::CSR_VIEW_BOTTOM: view_bottom_ff <= csr_chan.data;
            rcn_pkg::CSR_POINT_X:     point_x_ff     <= csr_chan.data;
            rcn_pkg::CSR_POINT_Y:     point_y_ff     <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Point test, clipping to the view and the minimum side check.
   always_comb begin
      bl = 17'(signed'(req_chan.box_left));
      bt = 17'(signed'(req_chan.box_top));
      br = 17'(signed'(req_chan.box_right));
      bb = 17'(signed'(req_chan.box_bottom));
      vl = 17'(view_left_ff);
      vt = 17'(view_top_ff);
      vr = 17'(view_right_ff);
      vb = 17'(view_bottom_ff);
      px = 17'(point_x_ff);
      py = 17'(point_y_ff);
      hits_point = (px >= bl) && (px < br) && (py >= bt) && (py < bb);
      cl = (bl > vl) ? bl : vl;
      ct = (bt > vt) ? bt : vt;
      cr = (br < vr) ? br : vr;
      cb = (bb < vb) ? bb : vb;
      big_enough = ((cr - cl) >= rcn_pkg::MIN_SIDE) && ((cb - ct) >= rcn_pkg::MIN_SIDE);
      rel_l = cl - vl;
      rel_t = ct - vt;
      rel_r = cr - vl;
      rel_b = cb - vt;
   end

   // A request is taken whenever the queue has room.
   assign req_chan.ready       = !q_status.full;
   assign q_push               = req_chan.valid && !q_status.full;
   assign q_entry.box.left     = rel_l[15:0];
   assign q_entry.box.top      = rel_t[15:0];
   assign q_entry.box.right    = rel_r[15:0];
   assign q_entry.box.bottom   = rel_b[15:0];
   assign q_entry.keep         = hits_point && big_enough;
   assign q_entry.last         = req_chan.last_box;

endmodule

`default_nettype wire

/* rtl/rcn_queue.sv */
// ----------------------------------------------------------------------------
// Rectangle candidate nesting: decoupling queue
// Two-entry queue of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module rcn_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  rcn_pkg::queue_ctrl_type    ctrl,
   input  rcn_pkg::entry_type         wr_entry,
   output rcn_pkg::entry_type         rd_entry,
   output rcn_pkg::queue_status_type  status
);

   rcn_pkg::entry_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         fill_ff, fill_in;
   logic               do_push, do_pop;

   assign status.full  = (fill_ff == 2'd2);
   assign status.empty = (fill_ff == 2'd0);
   assign do_push      = ctrl.push && !status.full;
   assign do_pop       = ctrl.pop && !status.empty;
   assign rd_entry     = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

`default_nettype wire

/* rtl/rcn_back.sv */
// ----------------------------------------------------------------------------
// Rectangle candidate nesting: back part
// Removes duplicates, stores boxes, then sorts by area and finds parents.
// ----------------------------------------------------------------------------
`default_nettype none

module rcn_back #(
   parameter int unsigned MAX_BOXES = 64
) (
   input  wire                        clock,
   input  wire                        reset,
   input  rcn_pkg::queue_status_type  q_status,
   input  rcn_pkg::entry_type         q_entry,
   output logic                       q_pop,
   rcn_rsp_if.source                  rsp_chan
);

   localparam int unsigned IDX_W = $clog2(MAX_BOXES);
   localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);
   localparam int unsigned KEY_W = rcn_pkg::AREA_W + IDX_W;

   // Box and area stores, one read port each, same scan address.
   rcn_pkg::box_type             box_mem  [MAX_BOXES];
   logic [rcn_pkg::AREA_W-1:0]   area_mem [MAX_BOXES];
   rcn_pkg::box_type             box_rd_ff;
   logic [rcn_pkg::AREA_W-1:0]   area_rd_ff;

   rcn_pkg::back_state_type      state_ff, state_in;
   rcn_pkg::entry_type           entry_ff, entry_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         ovf_ff, ovf_in;
   logic [CNT_W-1:0]             sc_ff, sc_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]             rd_idx_ff, rd_idx_in;
   logic                         dup_ff, dup_in;
   logic [rcn_pkg::AREA_W-1:0]   area_ff, area_in;
   logic [KEY_W-1:0]             best_ff, best_in;
   logic                         best_vld_ff, best_vld_in;
   logic [KEY_W-1:0]             prev_ff, prev_in;
   logic                         have_prev_ff, have_prev_in;
   rcn_pkg::box_type             cur_box_ff, cur_box_in;
   logic [CNT_W-1:0]             rank_ff, rank_in;
   logic [rcn_pkg::PARENT_W-1:0] parent_ff, parent_in;
   logic [IDX_W-1:0]             k_ff, k_in;
   rcn_pkg::result_type          rsp_ff, rsp_in;
   logic                         rsp_vld_ff, rsp_vld_in;

   logic                         scanning, scan_done, slot_free, wr_en;
   logic [KEY_W-1:0]             rd_key;
   logic [15:0]                  width, height;
   logic                         is_final;

   assign scanning  = (state_ff == rcn_pkg::ST_DUP) || (state_ff == rcn_pkg::ST_SEL) ||
                      (state_ff == rcn_pkg::ST_PAR) || (state_ff == rcn_pkg::ST_RANK);
   assign scan_done = (sc_ff == cnt_ff) && !rd_vld_ff;
   assign slot_free = !rsp_vld_ff || rsp_chan.ready;
   assign rd_key    = {area_rd_ff, rd_idx_ff};
   assign width     = entry_ff.box.right - entry_ff.box.left;
   assign height    = entry_ff.box.bottom - entry_ff.box.top;
   assign is_final  = (CNT_W'(k_ff) + CNT_W'(1)) == cnt_ff;
   assign wr_en     = (state_ff == rcn_pkg::ST_APPEND) && (cnt_ff < CNT_W'(MAX_BOXES));

   // Store write at the fill count and registered scan read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         box_mem[cnt_ff[IDX_W-1:0]]  <= entry_ff.box;
         area_mem[cnt_ff[IDX_W-1:0]] <= area_ff;
      end
      box_rd_ff  <= box_mem[sc_ff[IDX_W-1:0]];
      area_rd_ff <= area_mem[sc_ff[IDX_W-1:0]];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rcn_pkg::ST_IDLE: begin
            if (!q_status.empty) begin
               if (q_entry.keep) begin
                  state_in = (cnt_ff == '0) ? rcn_pkg::ST_AREA : rcn_pkg::ST_DUP;
               end else begin
                  state_in = rcn_pkg::ST_END;
               end
            end
         end
         rcn_pkg::ST_DUP:    if (scan_done) state_in = dup_ff ? rcn_pkg::ST_END : rcn_pkg::ST_AREA;
         rcn_pkg::ST_AREA:   state_in = rcn_pkg::ST_APPEND;
         rcn_pkg::ST_APPEND: state_in = rcn_pkg::ST_END;
         rcn_pkg::ST_END: begin
            if (!entry_ff.last) begin
               state_in = rcn_pkg::ST_IDLE;
            end else begin
               state_in = (cnt_ff == '0) ? rcn_pkg::ST_EMPTY : rcn_pkg::ST_SEL;
            end
         end
         rcn_pkg::ST_EMPTY:  if (slot_free) state_in = rcn_pkg::ST_IDLE;
         rcn_pkg::ST_SEL:    if (scan_done) state_in = rcn_pkg::ST_PAR;
         rcn_pkg::ST_PAR: begin
            if (scan_done) state_in = best_vld_ff ? rcn_pkg::ST_RANK : rcn_pkg::ST_EMIT;
         end
         rcn_pkg::ST_RANK:   if (scan_done) state_in = rcn_pkg::ST_EMIT;
         rcn_pkg::ST_EMIT: begin
            if (slot_free) state_in = is_final ? rcn_pkg::ST_IDLE : rcn_pkg::ST_SEL;
         end
         default:            state_in = rcn_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      q_pop        = 1'b0;
      entry_in     = entry_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      sc_in        = '0;
      rd_vld_in    = 1'b0;
      rd_idx_in    = sc_ff[IDX_W-1:0];
      dup_in       = dup_ff;
      area_in      = area_ff;
      best_in      = best_ff;
      best_vld_in  = best_vld_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      cur_box_in   = cur_box_ff;
      rank_in      = rank_ff;
      parent_in    = parent_ff;
      k_in         = k_ff;
      rsp_in       = rsp_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_chan.ready;

      // Scan address issue, one stored entry per cycle; the address returns
      // to zero once a scan is done so that the next scan starts afresh.
      if (scanning && (sc_ff < cnt_ff)) begin
         sc_in     = sc_ff + CNT_W'(1);
         rd_vld_in = 1'b1;
      end else if (scanning && !scan_done) begin
         sc_in = sc_ff;
      end

      case (state_ff)
         rcn_pkg::ST_IDLE: begin
            q_pop    = !q_status.empty;
            entry_in = q_entry;
            dup_in   = 1'b0;
         end
         rcn_pkg::ST_DUP: begin
            if (rd_vld_ff && (box_rd_ff == entry_ff.box)) dup_in = 1'b1;
         end
         rcn_pkg::ST_AREA: begin
            area_in = rcn_pkg::AREA_W'(width) * rcn_pkg::AREA_W'(height);
         end
         rcn_pkg::ST_APPEND: begin
            if (wr_en) cnt_in = cnt_ff + CNT_W'(1);
            else ovf_in = 1'b1;
         end
         rcn_pkg::ST_END: begin
            best_vld_in  = 1'b0;
            have_prev_in = 1'b0;
            k_in         = '0;
         end
         rcn_pkg::ST_EMPTY: begin
            if (slot_free) begin
               rsp_in            = '0;
               rsp_in.none_found = 1'b1;
               rsp_in.final_item = 1'b1;
               rsp_vld_in        = 1'b1;
               ovf_in            = 1'b0;
            end
         end
         rcn_pkg::ST_SEL: begin
            // Smallest key above the one emitted last.
            if (rd_vld_ff && (!have_prev_ff || (rd_key > prev_ff)) &&
                (!best_vld_ff || (rd_key < best_ff))) begin
               best_in     = rd_key;
               best_vld_in = 1'b1;
               cur_box_in  = box_rd_ff;
            end
            if (scan_done) begin
               prev_in      = best_ff;
               have_prev_in = 1'b1;
               best_vld_in  = 1'b0;
            end
         end
         rcn_pkg::ST_PAR: begin
            // First later box in area order that holds the current one.
            if (rd_vld_ff && (rd_key > prev_ff) && rcn_pkg::encloses(box_rd_ff, cur_box_ff) &&
                (!best_vld_ff || (rd_key < best_ff))) begin
               best_in     = rd_key;
               best_vld_in = 1'b1;
            end
            rank_in = '0;
            if (scan_done && !best_vld_ff) parent_in = rcn_pkg::PARENT_NONE;
         end
         rcn_pkg::ST_RANK: begin
            // The parent's output index is the number of smaller keys.
            if (rd_vld_ff && (rd_key < best_ff)) rank_in = rank_ff + CNT_W'(1);
            if (scan_done) parent_in = rcn_pkg::PARENT_W'(rank_ff);
         end
         rcn_pkg::ST_EMIT: begin
            if (slot_free) begin
               rsp_in.box          = cur_box_ff;
               rsp_in.parent_index = parent_ff;
               rsp_in.none_found   = 1'b0;
               rsp_in.dropped_some = ovf_ff;
               rsp_in.final_item   = is_final;
               rsp_vld_in          = 1'b1;
               best_vld_in         = 1'b0;
               k_in                = k_ff + IDX_W'(1);
               if (is_final) begin
                  cnt_in = '0;
                  ovf_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcn_pkg::ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         sc_ff        <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         best_vld_ff  <= 1'b0;
         have_prev_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         sc_ff        <= sc_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
         best_vld_ff  <= best_vld_in;
         have_prev_ff <= have_prev_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff   <= entry_in;
      rd_idx_ff  <= rd_idx_in;
      dup_ff     <= dup_in;
      area_ff    <= area_in;
      best_ff    <= best_in;
      prev_ff    <= prev_in;
      cur_box_ff <= cur_box_in;
      rank_ff    <= rank_in;
      parent_ff  <= parent_in;
      k_ff       <= k_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.out_left     = rsp_ff.box.left;
   assign rsp_chan.out_top      = rsp_ff.box.top;
   assign rsp_chan.out_right    = rsp_ff.box.right;
   assign rsp_chan.out_bottom   = rsp_ff.box.bottom;
   assign rsp_chan.parent_index = rsp_ff.parent_index;
   assign rsp_chan.none_found   = rsp_ff.none_found;
   assign rsp_chan.dropped_some = rsp_ff.dropped_some;
   assign rsp_chan.final_item   = rsp_ff.final_item;

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_BOXES))
      else $error("box count above capacity");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (CNT_W'(rd_idx_ff) < cnt_ff))
      else $error("store read beyond the fill count");

   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rcn_pkg::ST_EMIT && slot_free && is_final) |=> (cnt_ff == '0 && !ovf_ff))
      else $error("store not emptied at end of run");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == rcn_pkg::ST_IDLE))
      else $error("queue popped while busy");
`endif

endmodule

`default_nettype wire

/* rtl/rect_candidate_nesting_top.sv */
// ----------------------------------------------------------------------------
// Rectangle candidate nesting: top level
// Keeps boxes holding a point, clipped to the view, and emits them by area
// with the index of the smallest enclosing box.
//
//   Channel    Direction  Carries
//   req_chan   in         one screen rectangle and the end-of-list flag
//   rsp_chan   out        one view-relative box with parent and flags
//   csr_chan   in         register index and 16-bit data
//
// In the back part, the duplicate check for each rectangle reads the box store one
// entry per cycle through its single read port. At the end of a list, each emitted
// box takes up to three scans of the store (select, parent and rank).
// Reset is synchronous and clears all control state; the store needs no clearing.
// Requests wait in a two-entry queue; a full result register stalls emission.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_candidate_nesting_top #(
   parameter int unsigned MAX_BOXES = 64
) (
   input  wire       clock,
   input  wire       reset,
   rcn_req_if.sink   req_chan,
   rcn_rsp_if.source rsp_chan,
   rcn_csr_if.sink   csr_chan
);

   rcn_pkg::queue_status_type q_status;
   rcn_pkg::queue_ctrl_type   q_ctrl;
   rcn_pkg::entry_type        wr_entry;
   rcn_pkg::entry_type        rd_entry;
   logic                      push, pop;

   assign q_ctrl.push = push;
   assign q_ctrl.pop  = pop;

   rcn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .q_status (q_status),
      .q_push   (push),
      .q_entry  (wr_entry)
   );

   rcn_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (q_ctrl),
      .wr_entry (wr_entry),
      .rd_entry (rd_entry),
      .status   (q_status)
   );

   rcn_back #(
      .MAX_BOXES (MAX_BOXES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_entry  (rd_entry),
      .q_pop    (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Rectangle candidate nesting: testbench
// Drives lists of screen rectangles under several view and point settings,
// predicts the kept, sorted and nested boxes of each list and checks every
// result field against that prediction, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

// Scoreboard: holds the register copy, the kept boxes and the expected results.
class nesting_scoreboard;
   int view_l, view_t, view_r, view_b, pt_x, pt_y;
   rcn_pkg::box_type kept_boxes[$];
   bit lost_to_full;
   rcn_pkg::result_type expected_results[$];
   int mismatches;
   int results_seen;
   int lists_done;
   int overflow_lists;

   function void set_register(rcn_pkg::csr_index_type idx, logic [15:0] value);
      int v;
      v = $signed(value);
      case (idx)
         rcn_pkg::CSR_VIEW_LEFT:   view_l = v;
         rcn_pkg::CSR_VIEW_TOP:    view_t = v;
         rcn_pkg::CSR_VIEW_RIGHT:  view_r = v;
         rcn_pkg::CSR_VIEW_BOTTOM: view_b = v;
         rcn_pkg::CSR_POINT_X:     pt_x = v;
         rcn_pkg::CSR_POINT_Y:     pt_y = v;
         default: ;
      endcase
   endfunction

   function longint box_area(rcn_pkg::box_type x);
      box_area = longint'(x.right - x.left) * longint'(x.bottom - x.top);
   endfunction

   function bit holds(rcn_pkg::box_type outer, rcn_pkg::box_type inner);
      holds = inner.left >= outer.left && inner.top >= outer.top &&
              inner.right <= outer.right && inner.bottom <= outer.bottom;
   endfunction

   // Note one accepted request and, at the end of a list, queue its results.
   function void note_request(logic [15:0] l, logic [15:0] t, logic [15:0] r,
                              logic [15:0] b, logic last);
      int sl, st, sr, sb, cl, ct, cr, cb;
      rcn_pkg::box_type nb;
      rcn_pkg::result_type res;
      bit dup;
      int order[$];
      int n, j, tmp;
      sl = $signed(l);
      st = $signed(t);
      sr = $signed(r);
      sb = $signed(b);
      if (pt_x >= sl && pt_x < sr && pt_y >= st && pt_y < sb) begin
         cl = sl > view_l ? sl : view_l;
         ct = st > view_t ? st : view_t;
         cr = sr < view_r ? sr : view_r;
         cb = sb < view_b ? sb : view_b;
         if (cr - cl >= 8 && cb - ct >= 8) begin
            nb.left = 16'(cl - view_l);
            nb.top = 16'(ct - view_t);
            nb.right = 16'(cr - view_l);
            nb.bottom = 16'(cb - view_t);
            dup = 0;
            foreach (kept_boxes[i])
               if (kept_boxes[i] == nb) dup = 1;
            if (!dup) begin
               if (kept_boxes.size() < 64) kept_boxes.insert(kept_boxes.size(), nb);
               else lost_to_full = 1;
            end
         end
      end
      if (!last) return;
      lists_done++;
      if (lost_to_full) overflow_lists++;
      n = kept_boxes.size();
      if (n == 0) begin
         res = '0;
         res.none_found = 1;
         res.final_item = 1;
         expected_results.insert(expected_results.size(), res);
      end else begin
         // Stable insertion sort by area.
         for (int i = 0; i < n; i++) begin
            order.insert(order.size(), i);
            j = i;
            while (j > 0 && box_area(kept_boxes[order[j-1]]) >
                            box_area(kept_boxes[order[j]])) begin
               tmp = order[j];
               order[j] = order[j-1];
               order[j-1] = tmp;
               j--;
            end
         end
         for (int i = 0; i < n; i++) begin
            res = '0;
            res.box = kept_boxes[order[i]];
            res.parent_index = rcn_pkg::PARENT_NONE;
            for (int k = n - 1; k > i; k--)
               if (holds(kept_boxes[order[k]], res.box)) res.parent_index = 7'(k);
            res.dropped_some = lost_to_full;
            res.final_item = (i == n - 1);
            expected_results.insert(expected_results.size(), res);
         end
      end
      kept_boxes.delete();
      lost_to_full = 0;
   endfunction

   // Compare one accepted result with the oldest expectation.
   function void check_result(rcn_pkg::result_type got);
      rcn_pkg::result_type want;
      results_seen++;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %p", got);
         return;
      end
      want = expected_results.pop_front();
      if (got.box.left !== want.box.left || got.box.top !== want.box.top ||
          got.box.right !== want.box.right || got.box.bottom !== want.box.bottom ||
          got.parent_index !== want.parent_index || got.none_found !== want.none_found ||
          got.dropped_some !== want.dropped_some || got.final_item !== want.final_item) begin
         mismatches++;
         if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
      end
   endfunction
endclass

module tb_top;

   localparam int CYCLE_LIMIT = 3000000;

   logic clock = 0;
   logic reset = 1;
   int   cycles = 0;
   int   requests_sent = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   list_no = 0;
   logic [15:0] recent_boxes[$];

   rcn_req_if req_chan();
   rcn_rsp_if rsp_chan();
   rcn_csr_if csr_chan();

   nesting_scoreboard board = new();

   rect_candidate_nesting_top uut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   always #5 clock = ~clock;

   // Cycle count and run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Watch both channels at the rising edge.
   always @(posedge clock) begin
      rcn_pkg::result_type got;
      if (!reset && req_chan.valid && req_chan.ready)
         board.note_request(req_chan.box_left, req_chan.box_top, req_chan.box_right,
                            req_chan.box_bottom, req_chan.last_box);
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.box.left = rsp_chan.out_left;
         got.box.top = rsp_chan.out_top;
         got.box.right = rsp_chan.out_right;
         got.box.bottom = rsp_chan.out_bottom;
         got.parent_index = rsp_chan.parent_index;
         got.none_found = rsp_chan.none_found;
         got.dropped_some = rsp_chan.dropped_some;
         got.final_item = rsp_chan.final_item;
         board.check_result(got);
      end
   end

   // Result ready toggles at the falling edge according to the stall rate.
   always @(negedge clock)
      rsp_chan.ready = ($urandom_range(99) >= recv_stall_pct);

   initial begin
      req_chan.valid = 0;
      req_chan.box_left = 0;
      req_chan.box_top = 0;
      req_chan.box_right = 0;
      req_chan.box_bottom = 0;
      req_chan.last_box = 0;
      csr_chan.valid = 0;
      csr_chan.index = rcn_pkg::CSR_VIEW_LEFT;
      csr_chan.data = 0;
      rsp_chan.ready = 1;
   end

   // Send one request; called at a falling edge and returns at one.
   task automatic send_box(int l, int t, int r, int b, bit last);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_chan.valid = 1;
      req_chan.box_left = 16'(l);
      req_chan.box_top = 16'(t);
      req_chan.box_right = 16'(r);
      req_chan.box_bottom = 16'(b);
      req_chan.last_box = last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      req_chan.valid = 0;
      requests_sent++;
   endtask

   task automatic write_register(rcn_pkg::csr_index_type idx, int value);
      csr_chan.valid = 1;
      csr_chan.index = idx;
      csr_chan.data = 16'(value);
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      board.set_register(idx, 16'(value));
      @(negedge clock);
      csr_chan.valid = 0;
   endtask

   task automatic write_settings(int vl, int vt, int vr, int vb, int px, int py);
      write_register(rcn_pkg::CSR_VIEW_LEFT, vl);
      write_register(rcn_pkg::CSR_VIEW_TOP, vt);
      write_register(rcn_pkg::CSR_VIEW_RIGHT, vr);
      write_register(rcn_pkg::CSR_VIEW_BOTTOM, vb);
      write_register(rcn_pkg::CSR_POINT_X, px);
      write_register(rcn_pkg::CSR_POINT_Y, py);
   endtask

   // Wait for every expected result, then let the block settle.
   task automatic drain();
      while (board.expected_results.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   function automatic int clamp16(int v);
      clamp16 = v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
   endfunction

   function automatic int pick_offset();
      case ($urandom_range(5))
         0: pick_offset = 0;
         1: pick_offset = $urandom_range(8);
         2: pick_offset = 8 * $urandom_range(4);
         3: pick_offset = $urandom_range(64);
         4: pick_offset = $urandom_range(2000);
         default: pick_offset = $urandom_range(65535);
      endcase
   endfunction

   // One random request: mostly boxes around the point, some repeats and noise.
   task automatic send_random_box(bit last);
      int l, t, r, b, kind;
      kind = $urandom_range(99);
      if (kind < 15 && recent_boxes.size() >= 4) begin
         l = $signed(recent_boxes[0]);
         t = $signed(recent_boxes[1]);
         r = $signed(recent_boxes[2]);
         b = $signed(recent_boxes[3]);
      end else if (kind < 30) begin
         l = $signed(16'($urandom));
         t = $signed(16'($urandom));
         r = $signed(16'($urandom));
         b = $signed(16'($urandom));
      end else begin
         l = clamp16(board.pt_x - pick_offset());
         t = clamp16(board.pt_y - pick_offset());
         r = clamp16(board.pt_x + 1 + pick_offset());
         b = clamp16(board.pt_y + 1 + pick_offset());
      end
      if ($urandom_range(3) == 0) begin
         recent_boxes.delete();
         recent_boxes.insert(recent_boxes.size(), 16'(l));
         recent_boxes.insert(recent_boxes.size(), 16'(t));
         recent_boxes.insert(recent_boxes.size(), 16'(r));
         recent_boxes.insert(recent_boxes.size(), 16'(b));
      end
      send_box(l, t, r, b, last);
   endtask

   // Seventy distinct boxes around the point so that the store fills up.
   task automatic send_overflow_list();
      for (int k = 0; k < 70; k++)
         send_box(clamp16(board.pt_x - 8 - k), clamp16(board.pt_y - 8),
                  clamp16(board.pt_x + 8), clamp16(board.pt_y + 8 + (k % 3)), k == 69);
   endtask

   task automatic choose_settings(int which);
      int vl, vt, px, py;
      case (which % 6)
         0: write_settings(-32768, -32768, 32767, 32767, 0, 0);
         1: begin
            vl = $signed(16'($urandom_range(65535)));
            vt = $signed(16'($urandom_range(65535)));
            vl = vl > 30000 ? 30000 : vl;
            vt = vt > 30000 ? 30000 : vt;
            px = vl + $urandom_range(600);
            py = vt + $urandom_range(400);
            write_settings(vl, vt, clamp16(vl + 640), clamp16(vt + 480),
                           clamp16(px), clamp16(py));
         end
         2: write_settings(500, 400, 100, 50, 300, 200);
         3: write_settings(-32768, -32768, 32767, 32767, 32766, -32768);
         4: write_settings($signed(16'($urandom)), $signed(16'($urandom)),
                           $signed(16'($urandom)), $signed(16'($urandom)),
                           $signed(16'($urandom)), $signed(16'($urandom)));
         default: write_settings(0, 0, 1920, 1080, 960, 540);
      endcase
   endtask

   initial begin
      int len;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Registers at reset give an empty view: the list keeps nothing.
      send_box(-10, -10, 10, 10, 1);
      drain();
      write_settings(-32768, -32768, 32767, 32767, 0, 0);
      // Extremes, the side limit, half-open edges, a repeat and an area tie.
      send_box(-32768, -32768, 32767, 32767, 0);
      send_box(0, 0, 8, 8, 0);
      send_box(0, 0, 7, 8, 0);
      send_box(1, 0, 10, 10, 0);
      send_box(-8, -8, 0, 8, 0);
      send_box(0, 0, 8, 8, 0);
      send_box(-4, -4, 4, 4, 0);
      send_box(-100, -100, 100, 100, 1);
      // A list whose only box misses the point.
      send_box(5, 5, 50, 50, 1);
      // Nesting chain with boxes of equal area side by side.
      send_box(-20, -20, 20, 20, 0);
      send_box(-10, -10, 10, 10, 0);
      send_box(-10, -12, 10, 8, 0);
      send_box(-30, -5, 30, 5, 1);
      drain();
      write_settings(500, 400, 100, 50, 300, 200);
      send_box(0, 0, 1000, 1000, 1);
      drain();

      // Random lists across settings and idling phases.
      while (requests_sent < 460) begin
         if (list_no % 6 == 0) begin
            drain();
            choose_settings(list_no / 6);
         end
         case ((list_no / 3) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         if (list_no == 5 || list_no == 29) send_overflow_list();
         else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
            for (int k = 0; k < len; k++) send_random_box(k == len - 1);
         end
         list_no++;
      end

      recv_stall_pct = 0;
      drain();
      $display("covered %0d requests in %0d lists, %0d with a full store, %0d results checked",
               requests_sent, board.lists_done, board.overflow_lists, board.results_seen);
      if (board.mismatches == 0 && board.expected_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.expected_results.size());
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

`default_nettype wire

/* rect_candidate_nesting_top.f */
rtl/rcn_pkg.sv
rtl/rcn_if.sv
rtl/rcn_front.sv
rtl/rcn_queue.sv
rtl/rcn_back.sv
rtl/rect_candidate_nesting_top.sv
sim/tb_top.sv
